// ----- rtl/slotted_bounded_list_table_assert.svh -----
// Assertion macros used by the checker file of the list table.
`ifndef SLOTTED_BOUNDED_LIST_TABLE_ASSERT_SVH
`define SLOTTED_BOUNDED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SBLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list table assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SBLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list table assertion failed");

`endif

// ----- rtl/sblt_pkg.sv -----
package sblt_pkg;

   localparam int COMMAND_WIDTH  = 3;
   localparam int POSITION_WIDTH = 4;
   localparam int REQ_VALUE_WIDTH = 32;
   localparam int SIZE_WIDTH     = 8;
   localparam int STATUS_WIDTH   = 4;
   localparam int COUNT_WIDTH    = 5;

   localparam logic [COMMAND_WIDTH-1:0] CMD_CREATE = 3'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_APPEND = 3'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_DROP   = 3'd2;
   localparam logic [COMMAND_WIDTH-1:0] CMD_REMOVE = 3'd3;
   localparam logic [COMMAND_WIDTH-1:0] CMD_RESIZE = 3'd4;
   localparam logic [COMMAND_WIDTH-1:0] CMD_QUERY  = 3'd5;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK           = 4'd0,
      ST_BAD_SLOT     = 4'd1,
      ST_EXISTS       = 4'd2,
      ST_BAD_SIZE     = 4'd3,
      ST_NO_MEMORY    = 4'd4,
      ST_NO_LIST      = 4'd5,
      ST_FULL         = 4'd6,
      ST_EMPTY        = 4'd7,
      ST_NOT_FOUND    = 4'd8,
      ST_BAD_NEW_SIZE = 4'd9
   } status_type;

endpackage

// ----- rtl/slotted_bounded_list_table.sv -----
// Slotted bounded list table.
// Request channel (req_valid / req_stall): one command per transfer with a slot
// number from 1 to SLOTS, a value and a size or signed capacity delta.
// Response channel (rsp_valid / rsp_stall): one transfer per command carrying a
// status code and the element count of the addressed list after the command.
// The block works on one command at a time. Create, append, drop, resize,
// query and unknown commands go from execute to done, where the response
// register is loaded. Remove adds a search and a close-the-gap shift through
// the element memory's one read port, reading only entries below the count.
// The next request transfer is taken only after the previous command has
// gone through execute, response load and back to idle, with search and
// shift in between for a remove.
// The response sits in an output register: a new request is taken while an
// earlier response is still stalled, and its own response waits until that
// register is free. A stalled response holds its value.
// Reset (synchronous, active high) clears every slot's existence flag, count
// and capacity at once and empties the response register; the element memory
// is not cleared, since only entries below a list's count are ever read.
module slotted_bounded_list_table #(
   parameter int SLOTS        = 10,
   parameter int MAX_CAPACITY = 16,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic        [sblt_pkg::COMMAND_WIDTH-1:0]   req_command,
   input  logic        [sblt_pkg::POSITION_WIDTH-1:0]  req_slot_position,
   input  logic signed [sblt_pkg::REQ_VALUE_WIDTH-1:0] req_value,
   input  logic signed [sblt_pkg::SIZE_WIDTH-1:0]      req_size_or_delta,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic        [sblt_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic        [sblt_pkg::COUNT_WIDTH-1:0]     rsp_element_count
);
   import sblt_pkg::*;

   localparam int DEPTH = SLOTS * MAX_CAPACITY;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(MAX_CAPACITY + 1);
   localparam logic signed [9:0] MAX_CAP_S = 10'(MAX_CAPACITY);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EXEC   = 5'b00010,
      S_SEARCH = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [COMMAND_WIDTH-1:0]   cmd_ff;
   logic [SW-1:0]              slot_ff;
   logic                       slot_ok_ff;
   logic [AW-1:0]              base_ff;
   logic [VALUE_WIDTH-1:0]     val_ff;
   logic signed [SIZE_WIDTH-1:0] sd_ff;

   // per-slot descriptors
   logic          exists_ff [SLOTS];
   logic [CW-1:0] cap_ff    [SLOTS];
   logic [CW-1:0] count_ff  [SLOTS];

   logic          meta_we;
   logic          meta_exists_in;
   logic [CW-1:0] meta_cap_in;
   logic [CW-1:0] meta_count_in;

   // element memory
   logic [VALUE_WIDTH-1:0] element_store [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   mem_we, mem_re;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   logic [CW-1:0] idx_ff, idx_in;
   status_type    status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]  rsp_status_ff;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff;
   logic                     rsp_load;

   logic                 req_take;
   logic [POSITION_WIDTH-1:0] pos_m1;
   logic signed [63:0]   val_ext;

   logic          cur_exists;
   logic [CW-1:0] cur_cap, cur_count;
   logic [CW:0]   cnt_ext, idx_nx1, idx_nx2;
   logic signed [9:0] sd_ext, new_cap;
   logic [COUNT_WIDTH-1:0] resp_count;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign pos_m1    = req_slot_position - POSITION_WIDTH'(1);
   assign val_ext   = 64'(req_value);

   assign cur_exists = exists_ff[slot_ff];
   assign cur_cap    = cap_ff[slot_ff];
   assign cur_count  = count_ff[slot_ff];
   assign cnt_ext    = {1'b0, cur_count};
   assign idx_nx1    = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_nx2    = {1'b0, idx_ff} + (CW+1)'(2);
   assign sd_ext     = 10'(sd_ff);
   assign new_cap    = signed'(10'(cur_cap)) + sd_ext;
   assign resp_count = (slot_ok_ff && cur_exists) ? COUNT_WIDTH'(cur_count) : '0;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      wr_addr        = base_ff + AW'(idx_ff);
      rd_addr        = base_ff;
      wr_data        = val_ff;
      meta_we        = 1'b0;
      meta_exists_in = cur_exists;
      meta_cap_in    = cur_cap;
      meta_count_in  = cur_count;
      rsp_load       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_DONE;
            status_in = ST_OK;
            if (!slot_ok_ff) begin
               status_in = ST_BAD_SLOT;
            end else if (cmd_ff == CMD_CREATE) begin
               if (cur_exists) begin
                  status_in = ST_EXISTS;
               end else if (sd_ext < 10'sd1) begin
                  status_in = ST_BAD_SIZE;
               end else if (sd_ext > MAX_CAP_S) begin
                  status_in = ST_NO_MEMORY;
               end else begin
                  meta_we        = 1'b1;
                  meta_exists_in = 1'b1;
                  meta_cap_in    = CW'(sd_ff);
                  meta_count_in  = '0;
               end
            end else if (!cur_exists && (cmd_ff inside {[CMD_APPEND:CMD_QUERY]})) begin
               status_in = ST_NO_LIST;
            end else begin
               case (cmd_ff)
                  CMD_APPEND: begin
                     if (cur_count >= cur_cap) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        wr_addr       = base_ff + AW'(cur_count);
                        meta_we       = 1'b1;
                        meta_count_in = cur_count + CW'(1);
                     end
                  end
                  CMD_DROP: begin
                     if (cur_count == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        meta_we       = 1'b1;
                        meta_count_in = cur_count - CW'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (cur_count == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        // fetch the first entry and start the search
                        mem_re   = 1'b1;
                        idx_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_RESIZE: begin
                     if (new_cap < 10'sd1) begin
                        status_in = ST_BAD_NEW_SIZE;
                     end else if (new_cap > MAX_CAP_S) begin
                        status_in = ST_NO_MEMORY;
                     end else begin
                        meta_we       = 1'b1;
                        meta_cap_in   = CW'(new_cap);
                        meta_count_in = (cur_count > CW'(new_cap)) ? CW'(new_cap) : cur_count;
                     end
                  end
                  CMD_QUERY: begin
                     if (cur_count == '0) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // rd_data_ff holds the entry at idx_ff
            if (rd_data_ff == val_ff) begin
               if (idx_nx1 < cnt_ext) begin
                  mem_re   = 1'b1;
                  rd_addr  = base_ff + AW'(idx_nx1);
                  state_in = S_SHIFT;
               end else begin
                  meta_we       = 1'b1;
                  meta_count_in = cur_count - CW'(1);
                  status_in     = ST_OK;
                  state_in      = S_DONE;
               end
            end else if (idx_nx1 < cnt_ext) begin
               mem_re  = 1'b1;
               rd_addr = base_ff + AW'(idx_nx1);
               idx_in  = CW'(idx_nx1);
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            // rd_data_ff holds the entry above idx_ff: move it down one place
            mem_we  = 1'b1;
            wr_addr = base_ff + AW'(idx_ff);
            wr_data = rd_data_ff;
            if (idx_nx2 < cnt_ext) begin
               mem_re  = 1'b1;
               rd_addr = base_ff + AW'(idx_nx2);
               idx_in  = CW'(idx_nx1);
            end else begin
               meta_we       = 1'b1;
               meta_count_in = cur_count - CW'(1);
               status_in     = ST_OK;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // control state and slot descriptors
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            exists_ff[i] <= 1'b0;
            cap_ff[i]    <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (meta_we) begin
            exists_ff[slot_ff] <= meta_exists_in;
            cap_ff[slot_ff]    <= meta_cap_in;
            count_ff[slot_ff]  <= meta_count_in;
         end
      end
   end

   // latch the request and hold working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= req_command;
         slot_ok_ff <= (req_slot_position != '0) &&
                       (32'(req_slot_position) <= SLOTS);
         slot_ff    <= pos_m1[SW-1:0];
         base_ff    <= AW'(pos_m1) * AW'(MAX_CAPACITY);
         val_ff     <= val_ext[VALUE_WIDTH-1:0];
         sd_ff      <= req_size_or_delta;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= resp_count;
      end
   end

   // element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         element_store[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= element_store[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

// ----- rtl/sblt_checker.sv -----
`include "slotted_bounded_list_table_assert.svh"

module sblt_assertions (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic [sblt_pkg::STATUS_WIDTH-1:0]        rsp_status,
   input logic [sblt_pkg::COUNT_WIDTH-1:0]         rsp_element_count
);
   import sblt_pkg::*;

   logic                                rsp_stalled;
   logic [STATUS_WIDTH+COUNT_WIDTH-1:0] rsp_word;
   logic                                zero_count_status;

   assign rsp_stalled       = rsp_valid && rsp_stall;
   assign rsp_word          = {rsp_status, rsp_element_count};
   assign zero_count_status = (rsp_status == ST_BAD_SLOT) || (rsp_status == ST_NO_LIST) ||
                              (rsp_status == ST_BAD_SIZE) || (rsp_status == ST_EMPTY);

   // hold a stalled response
   `SBLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_word))

   // only defined status codes leave the block
   `SBLT_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_BAD_NEW_SIZE)

   // statuses that imply no list or an empty list carry a zero count
   `SBLT_ASSERT_NOW(a_zero_count, clock, reset, rsp_valid && zero_count_status, rsp_element_count == '0)

   // no response straight out of reset
   `SBLT_ASSERT_NOW(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind slotted_bounded_list_table sblt_assertions u_sblt_assertions (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_element_count (rsp_element_count)
);
